>>> hdl/sha256_pkg.sv
// sha-256 round constants, initial hash values, state encoding and round functions
`timescale 1ns / 1ps
`default_nettype none

package sha256_pkg;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] FILL_TOP = 6'd63;
    localparam logic [5:0] ROUND_TOP = 6'd63;
    localparam logic [2:0] WORD_TOP = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LEN,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    typedef logic [31:0] t_word;

    localparam t_word K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word rotr(input t_word v, input int unsigned n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word choose(input t_word e, input t_word f, input t_word g);
        choose = (e & f) ^ (~e & g);
    endfunction

    function automatic t_word majority(input t_word a, input t_word b, input t_word c);
        majority = (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

`default_nettype wire

>>> hdl/sha256_in_if.sv
// input channel: one message byte or a finish command per transfer
`timescale 1ns / 1ps
`default_nettype none

interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink (input valid, input op, input data_byte, output ready);
endinterface

`default_nettype wire

>>> hdl/sha256_out_if.sv
// output channel: one digest word per transfer
`timescale 1ns / 1ps
`default_nettype none

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;

    modport source (output valid, output digest_word, output word_index, output last,
                    input ready);
    modport sink (input valid, input digest_word, input word_index, input last,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/sha256_message_hasher.sv
// streaming sha-256 engine with one shared round unit under a small sequencer
//
//  channel  direction  payload                            handshake
//  i_in     sink       op, data_byte                      valid / ready
//  o_out    source     digest_word, word_index, last      valid / ready
//
// an absorbed byte is taken while idle; the 64th byte of a block starts 64 rounds
// through the single round unit followed by the chain addition. a finish shifts in
// padding and length one byte per cycle up to the block end, paused by a
// compression where padding crosses a block and by one S_PAD step before the
// length bytes; it compresses once or twice, then offers eight digest words.
// i_in.ready is high only while the sequencer is idle; o_out stalls hold the word.
// synchronous active-low reset restores the initial hash values and clears counts.
`timescale 1ns / 1ps
`default_nettype none

module sha256_message_hasher (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    sha256_in_if.sink      i_in,
    sha256_out_if.source   o_out
);

    sha256_pkg::t_state r_state, n_state;
    logic [5:0]         r_fill, n_fill;
    logic [63:0]        r_len, n_len;
    logic [5:0]         r_round, n_round;
    logic [2:0]         r_idx, n_idx;
    logic               r_pad, n_pad;
    logic               r_final, n_final;
    sha256_pkg::t_word  r_chain [8];
    sha256_pkg::t_word  n_chain [8];
    sha256_pkg::t_word  r_vars [8];
    sha256_pkg::t_word  n_vars [8];
    // oldest schedule word sits at the top of the window
    logic [511:0]       r_win, n_win;

    logic               w_byte_en;
    logic [7:0]         w_byte_val;
    sha256_pkg::t_word  w_t1;
    sha256_pkg::t_word  w_t2;
    sha256_pkg::t_word  w_new_w;
    sha256_pkg::t_word  w_w0;

    assign w_w0 = r_win[511:480];

    assign w_t1 = r_vars[7] + sha256_pkg::big_sigma1(r_vars[4])
                + sha256_pkg::choose(r_vars[4], r_vars[5], r_vars[6])
                + sha256_pkg::K[r_round] + w_w0;
    assign w_t2 = sha256_pkg::big_sigma0(r_vars[0])
                + sha256_pkg::majority(r_vars[0], r_vars[1], r_vars[2]);
    // taps: w[t-16], w[t-15], w[t-7], w[t-2]
    assign w_new_w = w_w0 + sha256_pkg::small_sigma0(r_win[479:448]) + r_win[223:192]
                   + sha256_pkg::small_sigma1(r_win[63:32]);

    assign o_out.digest_word = r_chain[r_idx];
    assign o_out.word_index  = r_idx;
    assign o_out.last        = (r_idx == sha256_pkg::WORD_TOP);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_len       = r_len;
        n_round     = r_round;
        n_idx       = r_idx;
        n_pad       = r_pad;
        n_final     = r_final;
        n_chain     = r_chain;
        n_vars      = r_vars;
        n_win       = r_win;
        w_byte_en   = 1'b0;
        w_byte_val  = 8'h00;
        i_in.ready  = 1'b0;
        o_out.valid = 1'b0;

        unique case (r_state)
            sha256_pkg::S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    w_byte_en = 1'b1;
                    if (i_in.op == sha256_pkg::OP_FINISH) begin
                        w_byte_val = sha256_pkg::PAD_MARK;
                        // byte count becomes the bit count for the length field
                        n_len      = r_len << 3;
                        n_pad      = 1'b1;
                        n_state    = sha256_pkg::S_PAD;
                    end else begin
                        w_byte_val = i_in.data_byte;
                        n_len      = r_len + 64'd1;
                    end
                end
            end
            sha256_pkg::S_PAD: begin
                if (r_fill == sha256_pkg::LEN_POS) begin
                    n_state = sha256_pkg::S_LEN;
                    n_final = 1'b1;
                end else begin
                    w_byte_en = 1'b1;
                end
            end
            sha256_pkg::S_LEN: begin
                w_byte_en  = 1'b1;
                w_byte_val = r_len[63:56];
                n_len      = r_len << 8;
            end
            sha256_pkg::S_ROUND: begin
                n_vars[0] = w_t1 + w_t2;
                n_vars[1] = r_vars[0];
                n_vars[2] = r_vars[1];
                n_vars[3] = r_vars[2];
                n_vars[4] = r_vars[3] + w_t1;
                n_vars[5] = r_vars[4];
                n_vars[6] = r_vars[5];
                n_vars[7] = r_vars[6];
                n_win     = {r_win[479:0], w_new_w};
                n_round   = r_round + 6'd1;
                if (r_round == sha256_pkg::ROUND_TOP) begin
                    n_state = sha256_pkg::S_ADD;
                end
            end
            sha256_pkg::S_ADD: begin
                for (int j = 0; j < 8; j++) begin
                    n_chain[j] = r_chain[j] + r_vars[j];
                end
                priority if (r_final) begin
                    n_state = sha256_pkg::S_OUT;
                end else if (r_pad) begin
                    n_state = sha256_pkg::S_PAD;
                end else begin
                    n_state = sha256_pkg::S_IDLE;
                end
            end
            sha256_pkg::S_OUT: begin
                o_out.valid = 1'b1;
                if (o_out.ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == sha256_pkg::WORD_TOP) begin
                        n_chain = sha256_pkg::H0;
                        n_pad   = 1'b0;
                        n_final = 1'b0;
                        n_state = sha256_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = sha256_pkg::S_IDLE;
            end
        endcase

        // every buffered byte, message or padding, enters the window here
        if (w_byte_en) begin
            n_win  = {r_win[503:0], w_byte_val};
            n_fill = r_fill + 6'd1;
            if (r_fill == sha256_pkg::FILL_TOP) begin
                n_state = sha256_pkg::S_ROUND;
                n_round = 6'd0;
                n_vars  = r_chain;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha256_pkg::S_IDLE;
            r_fill  <= 6'd0;
            r_len   <= 64'd0;
            r_round <= 6'd0;
            r_idx   <= 3'd0;
            r_pad   <= 1'b0;
            r_final <= 1'b0;
            r_chain <= sha256_pkg::H0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_len   <= n_len;
            r_round <= n_round;
            r_idx   <= n_idx;
            r_pad   <= n_pad;
            r_final <= n_final;
            r_chain <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vars <= n_vars;
        r_win  <= n_win;
    end

`ifndef NO_ASSERTIONS
    a_ready_excludes_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("input ready while a digest word is offered");

    a_rounds_on_block_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sha256_pkg::S_ROUND |-> r_fill == 6'd0)
        else $error("compression running on a partial block");

    a_round_end_adds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sha256_pkg::S_ROUND && r_round == sha256_pkg::ROUND_TOP
        |=> r_state == sha256_pkg::S_ADD)
        else $error("last round not followed by chain addition");

    a_restart_after_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && o_out.last
        |=> r_fill == 6'd0 && r_len == 64'd0 && r_chain[0] == sha256_pkg::H0[0]
            && i_in.ready)
        else $error("engine not reinitialized after final digest transfer");
`endif

endmodule

`default_nettype wire
